### src/dhkv_pkg.sv
// ----------------------------------------------------------------------------
// dhkv_pkg
// shared widths, codes and transaction types of the double-hashed table
// ----------------------------------------------------------------------------
package dhkv_pkg;

  localparam int TableSlots = 1021;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;
  localparam int IdxBits    = $clog2(TableSlots);
  localparam int CntBits    = $clog2(TableSlots + 1);
  localparam int OutCntBits = 10;
  localparam int QueueDepth = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_HIT     = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;

  // classified operation handed from front to back
  typedef struct packed {
    logic                 kind;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
    logic [IdxBits-1:0]   start;
    logic [IdxBits-1:0]   step;
  } op_t;

  // stored slot word: valid, key, value
  localparam int SlotBits = 1 + KeyBits + ValueBits;

endpackage

### src/dhkv_ram.sv
// ----------------------------------------------------------------------------
// dhkv_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module dhkv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // read first port: a write returns the old word, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/dhkv_front.sv
// ----------------------------------------------------------------------------
// dhkv_front
// accepts operations, works out the hash start and probe step by folding the
// key in two steps, and keeps a short queue for the back
// ----------------------------------------------------------------------------
module dhkv_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           valid,
  output logic                           ready,
  input  logic                           kind,
  input  logic [dhkv_pkg::KeyBits-1:0]   key,
  input  logic [dhkv_pkg::ValueBits-1:0] value,
  output logic                           op_valid,
  input  logic                           op_ready,
  output dhkv_pkg::op_t                  op
);

  localparam int KB = dhkv_pkg::KeyBits;
  localparam int IB = dhkv_pkg::IdxBits;
  localparam int QB = $clog2(dhkv_pkg::QueueDepth);
  // key split into four index-wide chunks
  localparam int PB = 4 * IB;
  localparam int FB = 2 * IB + 2;
  localparam int unsigned M1 = dhkv_pkg::TableSlots;
  localparam int unsigned M2 = dhkv_pkg::TableSlots - 2;
  // chunk weights, 2^(IB*n) reduced by each modulus
  localparam int unsigned A1 = (1 << IB) % M1;
  localparam int unsigned B1 = (A1 * A1) % M1;
  localparam int unsigned C1 = (B1 * A1) % M1;
  localparam int unsigned A2 = (1 << IB) % M2;
  localparam int unsigned B2 = (A2 * A2) % M2;
  localparam int unsigned C2 = (B2 * A2) % M2;

  logic                           busy;
  logic                           done;
  logic                           h_kind;
  logic [KB-1:0]                  h_key;
  logic [dhkv_pkg::ValueBits-1:0] h_value;
  logic [PB-1:0]                  kx;
  logic [FB-1:0]                  s1, s2, s1_next, s2_next;
  logic [FB-1:0]                  g1, g2, r1, r2;
  logic                           enq;

  dhkv_pkg::op_t q [dhkv_pkg::QueueDepth];
  logic [QB-1:0] wp, rp;
  logic [QB:0]   cnt;

  assign ready = !busy && !done;
  assign enq   = done && cnt != (QB+1)'(dhkv_pkg::QueueDepth);

  // first fold: weighted sum of the key chunks
  assign kx      = PB'(h_key);
  assign s1_next = FB'(kx[IB-1:0]) + FB'(kx[2*IB-1:IB]) * FB'(A1)
                 + FB'(kx[3*IB-1:2*IB]) * FB'(B1) + FB'(kx[4*IB-1:3*IB]) * FB'(C1);
  assign s2_next = FB'(kx[IB-1:0]) + FB'(kx[2*IB-1:IB]) * FB'(A2)
                 + FB'(kx[3*IB-1:2*IB]) * FB'(B2) + FB'(kx[4*IB-1:3*IB]) * FB'(C2);

  // second fold and one compare-subtract, enough for this slot count
  assign g1 = FB'(s1[FB-1:IB]) * FB'(A1) + FB'(s1[IB-1:0]);
  assign g2 = FB'(s2[FB-1:IB]) * FB'(A2) + FB'(s2[IB-1:0]);
  assign r1 = (g1 >= FB'(M1)) ? g1 - FB'(M1) : g1;
  assign r2 = (g2 >= FB'(M2)) ? g2 - FB'(M2) : g2;

  // hash sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (valid && ready) begin
      busy    <= 1'b1;
      h_kind  <= kind;
      h_key   <= key;
      h_value <= value;
    end else if (busy) begin
      s1   <= s1_next;
      s2   <= s2_next;
      busy <= 1'b0;
      done <= 1'b1;
    end else if (enq) begin
      done <= 1'b0;
    end
  end

  // operation queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (enq) begin
        q[wp].kind  <= h_kind;
        q[wp].key   <= h_key;
        q[wp].value <= h_value;
        q[wp].start <= IB'(r1);
        q[wp].step  <= IB'(r2 + 1'b1);
        wp          <= wp + 1'b1;
      end
      if (op_valid && op_ready) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (QB+1)'(enq) - (QB+1)'(op_valid && op_ready);
    end
  end

  assign op_valid = cnt != '0;
  assign op       = q[rp];

endmodule

### src/dhkv_back.sv
// ----------------------------------------------------------------------------
// dhkv_back
// walks the probe path in the slot memory, reading each slot in a read state
// and checking it in a check state, writes on insert and holds the result register
// ----------------------------------------------------------------------------
module dhkv_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  output logic                           op_ready,
  input  dhkv_pkg::op_t                  op,
  output logic                           valid,
  input  logic                           ready,
  output logic [2:0]                     status,
  output logic [dhkv_pkg::ValueBits-1:0] found_value,
  output logic [dhkv_pkg::OutCntBits-1:0] entry_count
);

  localparam int IB = dhkv_pkg::IdxBits;
  localparam int KB = dhkv_pkg::KeyBits;
  localparam int VB = dhkv_pkg::ValueBits;
  localparam int CB = dhkv_pkg::CntBits;
  localparam int WB = dhkv_pkg::SlotBits;
  localparam logic [IB:0] Slots = (IB+1)'(dhkv_pkg::TableSlots);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE} state_t;

  state_t        state;
  dhkv_pkg::op_t cur;
  logic [IB-1:0] idx;
  logic [CB-1:0] probes;
  logic [CB-1:0] count;
  logic [2:0]    res_status;
  logic [VB-1:0] res_value;
  logic          we;
  logic [IB-1:0] addr;
  logic [WB-1:0] wdata, rdata;
  logic          s_valid;
  logic [KB-1:0] s_key;
  logic [VB-1:0] s_value;
  logic [IB:0]   nsum;
  logic [IB-1:0] nidx;

  dhkv_ram #(.Width(WB), .Depth(dhkv_pkg::TableSlots)) u_slots (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign {s_valid, s_key, s_value} = rdata;
  assign nsum = {1'b0, idx} + {1'b0, cur.step};
  assign nidx = (nsum >= Slots) ? IB'(nsum - Slots) : IB'(nsum);
  assign op_ready = state == S_IDLE;

  // memory port control
  always_comb begin
    we    = 1'b0;
    addr  = idx;
    wdata = {1'b1, cur.key, cur.value};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      wdata = '0;
    end else if (state == S_CHECK && cur.kind == dhkv_pkg::KIND_INSERT) begin
      we = !s_valid || s_key == cur.key;
    end
  end

  // probe sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      count <= '0;
      valid <= 1'b0;
    end else begin
      if (valid && ready && state != S_DONE) begin
        valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == IB'(dhkv_pkg::TableSlots - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (op_valid) begin
            cur       <= op;
            idx       <= op.start;
            probes    <= '0;
            res_value <= '0;
            if (op.kind == dhkv_pkg::KIND_INSERT &&
                count >= CB'(dhkv_pkg::TableSlots)) begin
              res_status <= dhkv_pkg::ST_FULL;
              state      <= S_DONE;
            end else if (op.kind == dhkv_pkg::KIND_LOOKUP && count == '0) begin
              res_status <= dhkv_pkg::ST_MISS;
              state      <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          state <= S_DONE;
          if (cur.kind == dhkv_pkg::KIND_INSERT) begin
            if (!s_valid) begin
              res_status <= dhkv_pkg::ST_NEW;
              count      <= count + 1'b1;
            end else if (s_key == cur.key) begin
              res_status <= dhkv_pkg::ST_UPDATED;
            end else if (probes == CB'(dhkv_pkg::TableSlots - 1)) begin
              res_status <= dhkv_pkg::ST_FULL;
            end else begin
              state <= S_READ;
            end
          end else begin
            if (s_key == cur.key) begin
              res_status <= s_valid ? dhkv_pkg::ST_HIT : dhkv_pkg::ST_MISS;
              res_value  <= s_valid ? s_value : '0;
            end else if (s_value == '0 ||
                         probes == CB'(dhkv_pkg::TableSlots - 1)) begin
              res_status <= dhkv_pkg::ST_MISS;
            end else begin
              state <= S_READ;
            end
          end
          idx    <= nidx;
          probes <= probes + 1'b1;
        end
        S_DONE: begin
          if (!valid || ready) begin
            valid       <= 1'b1;
            status      <= res_status;
            found_value <= res_value;
            entry_count <= dhkv_pkg::OutCntBits'(count);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/double_hash_key_value_table.sv
// ----------------------------------------------------------------------------
// double_hash_key_value_table
// open-addressed key/value table with double hashing over 1021 slots
// ----------------------------------------------------------------------------
// The front folds each key into its start slot and probe step in the steps
// accept, fold and queue write, takes no new operation until the last one is
// written to the queue, and queues up to two operations; the back takes an
// operation while idle, reads and then checks each probed slot through the
// single slot memory port, and loads the result register. An insert on a full
// table or a lookup on an empty one skips the probing. A stalled result holds
// the back, and a full queue then holds the input. After reset a clearing pass
// sweeps all 1021 slots of the slot memory before the first operation is
// carried out.
module double_hash_key_value_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [dhkv_pkg::KeyBits-1:0]    key,
  input  logic [dhkv_pkg::ValueBits-1:0]  value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [dhkv_pkg::ValueBits-1:0]  found_value,
  output logic [dhkv_pkg::OutCntBits-1:0] entry_count
);

  logic          op_valid, op_ready;
  dhkv_pkg::op_t op;

  dhkv_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .kind(kind), .key(key), .value(value),
    .op_valid(op_valid), .op_ready(op_ready), .op(op)
  );

  dhkv_back u_back (
    .clk(clk), .rst(rst), .op_valid(op_valid), .op_ready(op_ready), .op(op),
    .valid(out_valid), .ready(out_ready), .status(status),
    .found_value(found_value), .entry_count(entry_count)
  );

endmodule

### src/dhkv_checker.sv
// ----------------------------------------------------------------------------
// dhkv_checker
// port-level checks on the table's result channel
// ----------------------------------------------------------------------------
module dhkv_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      status,
  input logic [dhkv_pkg::ValueBits-1:0]  found_value,
  input logic [dhkv_pkg::OutCntBits-1:0] entry_count
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result changed while stalled");

  // status within its codes
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= dhkv_pkg::ST_MISS)
    else $error("bad status code");

  // only a hit carries a value
  a_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dhkv_pkg::ST_HIT |-> found_value == '0)
    else $error("value without hit");

  // an insert of a new key shows a nonzero count
  a_new: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dhkv_pkg::ST_NEW |-> entry_count != '0)
    else $error("new entry with zero count");

endmodule

bind double_hash_key_value_table dhkv_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .found_value(found_value), .entry_count(entry_count)
);
